[sv/mandelbrot_escape_time_pixel_defines.svh]
// Assertion macros for the escape-time pixel engine.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define MET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/met_pkg.sv]
// Shared types, constants and saturation helpers of the escape-time engine.
// No dependencies.
`timescale 1ns / 1ps

package met_pkg;

  localparam int COORD_W = 32;            // signed Q4.28
  localparam int FRAC_W  = COORD_W - 4;
  localparam int DIM_W   = 12;
  localparam int CNT_W   = 16;
  localparam int ZOOM_W  = 31;
  localparam int SIZE_W  = 13;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int ACC_W   = COORD_W + 14;  // holds centre +/- 2^44

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_ZOOM_STEP   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_CENTER_REAL = 3'd1;
  localparam logic [IDX_W-1:0] CFG_CENTER_IMAG = 3'd2;
  localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd3;
  localparam logic [IDX_W-1:0] CFG_IMAGE_HGT   = 3'd4;
  localparam logic [IDX_W-1:0] CFG_ITER_LIMIT  = 3'd5;

  localparam logic [ZOOM_W-1:0] ZOOM_RST  = ZOOM_W'(1048576);
  localparam logic [SIZE_W-1:0] WIDTH_RST = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HGT_RST   = SIZE_W'(768);
  localparam logic [CNT_W-1:0]  LIMIT_RST = CNT_W'(256);

  localparam logic signed [ACC_W-1:0] FOUR = ACC_W'(1) <<< (FRAC_W + 2);
  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MWR  = 9'b000000010,  // centre_real - width*zoom/2
    ST_MXR  = 9'b000000100,  // + x*zoom
    ST_MHI  = 9'b000001000,  // centre_imag - height*zoom/2
    ST_MYI  = 9'b000010000,  // + y*zoom
    ST_SQR  = 9'b000100000,  // zr^2
    ST_SQI  = 9'b001000000,  // zi^2
    ST_CRS  = 9'b010000000,  // escape test, 2*zr*zi, update
    ST_DONE = 9'b100000000
  } met_state_e;

  typedef struct packed {
    logic [PROD_W-1:0]         raw;  // magnitude product, exact
    logic signed [COORD_W-1:0] fix;  // fixed-point product, truncated and saturated
  } met_mul_t;

  function automatic logic signed [ACC_W-1:0] ext_coord(input logic signed [COORD_W-1:0] v);
    ext_coord = {{(ACC_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    if (v > CMAX) begin
      sat_coord = CMAX[COORD_W-1:0];
    end else if (v < CMIN) begin
      sat_coord = CMIN[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

[sv/met_mul.sv]
// Shared signed-magnitude multiplier with fixed-point truncation and saturation.
// Depends on met_pkg.
`timescale 1ns / 1ps

module met_mul (
  input  logic signed [met_pkg::COORD_W-1:0] op_a_i,
  input  logic signed [met_pkg::COORD_W-1:0] op_b_i,
  output met_pkg::met_mul_t                  res_o
);

  localparam int QW = met_pkg::PROD_W - met_pkg::FRAC_W;

  logic                            neg;
  logic [met_pkg::COORD_W-1:0]     mag_a;
  logic [met_pkg::COORD_W-1:0]     mag_b;
  logic [met_pkg::PROD_W-1:0]      prod;
  logic [QW-1:0]                   quo;
  logic [QW-1:0]                   lim;

  assign neg   = op_a_i[met_pkg::COORD_W-1] ^ op_b_i[met_pkg::COORD_W-1];
  assign mag_a = op_a_i[met_pkg::COORD_W-1] ? -op_a_i : op_a_i;
  assign mag_b = op_b_i[met_pkg::COORD_W-1] ? -op_b_i : op_b_i;
  assign prod  = {{met_pkg::COORD_W{1'b0}}, mag_a} * {{met_pkg::COORD_W{1'b0}}, mag_b};
  assign quo   = prod[met_pkg::PROD_W-1:met_pkg::FRAC_W];
  // negative side reaches one further
  assign lim   = QW'(met_pkg::CMAX) + QW'(neg);

  always_comb begin
    res_o.raw = prod;
    if (quo > lim) begin
      res_o.fix = neg ? met_pkg::CMIN[met_pkg::COORD_W-1:0]
                      : met_pkg::CMAX[met_pkg::COORD_W-1:0];
    end else if (neg) begin
      res_o.fix = -quo[met_pkg::COORD_W-1:0];
    end else begin
      res_o.fix = quo[met_pkg::COORD_W-1:0];
    end
  end

endmodule

[sv/mandelbrot_escape_time_pixel.sv]
// Escape-time pixel engine: top level, sequencer and register file.
// Depends on met_pkg and met_mul.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o  | pixel_x_i, pixel_y_i
//  out     | out       | out_valid_o/out_ready_i| escape_count_o
//
// A word passes MWR, MXR, MHI and MYI, then SQR, SQI and CRS per escape test
// (escape index + 1 tests, or iteration_limit when bounded), then DONE: the
// single multiplier does the four mapping products, then zr^2, zi^2 and
// 2*zr*zi, one per cycle, for each test. The next word is taken back in IDLE.
// in_ready_o is high only while the sequencer is idle.
// The result sits in an output register, so a new word may be taken while it
// waits; a finished word holds in DONE until that register is free.
// rst_ni clears control state and loads the register defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [met_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [met_pkg::COORD_W-1:0]   cfg_data_i,
  // pixel in
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [met_pkg::DIM_W-1:0]     pixel_x_i,
  input  logic [met_pkg::DIM_W-1:0]     pixel_y_i,
  // escape count out
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [met_pkg::CNT_W-1:0]     escape_count_o
);

  localparam int CW = met_pkg::COORD_W;
  localparam int AW = met_pkg::ACC_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are taken at any time.
  // ---------------------------------------------------------------------------
  logic [met_pkg::ZOOM_W-1:0] zoom_q;
  logic signed [CW-1:0]       cen_re_q;
  logic signed [CW-1:0]       cen_im_q;
  logic [met_pkg::SIZE_W-1:0] width_q;
  logic [met_pkg::SIZE_W-1:0] height_q;
  logic [met_pkg::CNT_W-1:0]  limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q   <= met_pkg::ZOOM_RST;
      cen_re_q <= '0;
      cen_im_q <= '0;
      width_q  <= met_pkg::WIDTH_RST;
      height_q <= met_pkg::HGT_RST;
      limit_q  <= met_pkg::LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        met_pkg::CFG_ZOOM_STEP:   zoom_q   <= cfg_data_i[met_pkg::ZOOM_W-1:0];
        met_pkg::CFG_CENTER_REAL: cen_re_q <= cfg_data_i;
        met_pkg::CFG_CENTER_IMAG: cen_im_q <= cfg_data_i;
        met_pkg::CFG_IMAGE_WIDTH: width_q  <= cfg_data_i[met_pkg::SIZE_W-1:0];
        met_pkg::CFG_IMAGE_HGT:   height_q <= cfg_data_i[met_pkg::SIZE_W-1:0];
        met_pkg::CFG_ITER_LIMIT:  limit_q  <= cfg_data_i[met_pkg::CNT_W-1:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  met_pkg::met_state_e state_q, state_d;

  logic [met_pkg::DIM_W-1:0] px_q, px_d;
  logic [met_pkg::DIM_W-1:0] py_q, py_d;
  logic signed [AW-1:0]      acc_q, acc_d;   // centre minus half span
  logic signed [CW-1:0]      cr_q, cr_d;
  logic signed [CW-1:0]      ci_q, ci_d;
  logic signed [CW-1:0]      zr_q, zr_d;
  logic signed [CW-1:0]      zi_q, zi_d;
  logic signed [CW-1:0]      zr2_q, zr2_d;   // saturated zr + zr
  logic signed [CW-1:0]      r2_q, r2_d;
  logic signed [CW-1:0]      i2_q, i2_d;
  logic [met_pkg::CNT_W-1:0] n_q, n_d;       // iteration index

  logic                      out_valid_q, out_valid_d;
  logic [met_pkg::CNT_W-1:0] count_q, count_d;

  // shared multiplier
  logic signed [CW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  met_pkg::met_mul_t    mul_res;

  met_mul u_mul (
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .res_o  (mul_res)
  );

  // operand selection per step; mapping products are non-negative
  always_comb begin
    mul_a = {1'b0, zoom_q};
    mul_b = '0;
    unique case (state_q)
      met_pkg::ST_MWR: mul_b = {{(CW - met_pkg::SIZE_W){1'b0}}, width_q};
      met_pkg::ST_MXR: mul_b = {{(CW - met_pkg::DIM_W){1'b0}}, px_q};
      met_pkg::ST_MHI: mul_b = {{(CW - met_pkg::SIZE_W){1'b0}}, height_q};
      met_pkg::ST_MYI: mul_b = {{(CW - met_pkg::DIM_W){1'b0}}, py_q};
      met_pkg::ST_SQR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      met_pkg::ST_SQI: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      met_pkg::ST_CRS: begin
        mul_a = zr2_q;
        mul_b = zi_q;
      end
      default: ;
    endcase
  end

  // half span: floor(dim * zoom / 2); product stays below 2^44
  logic signed [AW-1:0] half_span;
  logic signed [AW-1:0] step_ofs;
  logic signed [AW-1:0] mag_sum;   // r2 + i2, both non-negative
  logic                 escaped;
  logic                 last_iter;
  logic                 slot_free;

  assign half_span = {1'b0, mul_res.raw[AW-1:1]};
  assign step_ofs  = mul_res.raw[AW-1:0];
  assign mag_sum   = met_pkg::ext_coord(r2_q) + met_pkg::ext_coord(i2_q);
  assign escaped   = mag_sum > met_pkg::FOUR;
  assign last_iter = n_q == (limit_q - met_pkg::CNT_W'(1));
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o = state_q == met_pkg::ST_IDLE;

  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    acc_d       = acc_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    zr2_d       = zr2_q;
    r2_d        = r2_q;
    i2_d        = i2_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    count_d     = count_q;

    unique case (state_q)
      met_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          px_d    = pixel_x_i;
          py_d    = pixel_y_i;
          state_d = met_pkg::ST_MWR;
        end
      end
      met_pkg::ST_MWR: begin
        acc_d   = met_pkg::ext_coord(cen_re_q) - half_span;
        state_d = met_pkg::ST_MXR;
      end
      met_pkg::ST_MXR: begin
        cr_d    = met_pkg::sat_coord(acc_q + step_ofs);
        zr_d    = met_pkg::sat_coord(acc_q + step_ofs);
        state_d = met_pkg::ST_MHI;
      end
      met_pkg::ST_MHI: begin
        acc_d   = met_pkg::ext_coord(cen_im_q) - half_span;
        state_d = met_pkg::ST_MYI;
      end
      met_pkg::ST_MYI: begin
        ci_d    = met_pkg::sat_coord(acc_q + step_ofs);
        zi_d    = met_pkg::sat_coord(acc_q + step_ofs);
        n_d     = '0;
        // a zero limit runs nothing and reports 0
        state_d = (limit_q == '0) ? met_pkg::ST_DONE : met_pkg::ST_SQR;
      end
      met_pkg::ST_SQR: begin
        r2_d    = mul_res.fix;
        zr2_d   = met_pkg::sat_coord(met_pkg::ext_coord(zr_q) + met_pkg::ext_coord(zr_q));
        state_d = met_pkg::ST_SQI;
      end
      met_pkg::ST_SQI: begin
        i2_d    = mul_res.fix;
        state_d = met_pkg::ST_CRS;
      end
      met_pkg::ST_CRS: begin
        if (escaped || last_iter) begin
          state_d = met_pkg::ST_DONE;
        end else begin
          zi_d    = met_pkg::sat_coord(met_pkg::ext_coord(mul_res.fix)
                                       + met_pkg::ext_coord(ci_q));
          zr_d    = met_pkg::sat_coord(met_pkg::ext_coord(r2_q) - met_pkg::ext_coord(i2_q)
                                       + met_pkg::ext_coord(cr_q));
          n_d     = n_q + met_pkg::CNT_W'(1);
          state_d = met_pkg::ST_SQR;
        end
      end
      met_pkg::ST_DONE: begin
        // index of escape, or limit - 1 when bounded: both are n
        if (slot_free) begin
          out_valid_d = 1'b1;
          count_d     = n_q;
          state_d     = met_pkg::ST_IDLE;
        end
      end
      default: state_d = met_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= met_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    acc_q   <= acc_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    zr_q    <= zr_d;
    zi_q    <= zi_d;
    zr2_q   <= zr2_d;
    r2_q    <= r2_d;
    i2_q    <= i2_d;
    n_q     <= n_d;
    count_q <= count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = count_q;

endmodule

[sv/met_chk.sv]
// Port checker for the escape-time pixel engine, bound to the top level.
// Depends on met_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_defines.svh"

module met_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [met_pkg::CNT_W-1:0]   escape_count_o
);

  logic in_take;

  assign in_take = in_valid_i && in_ready_o;

  // a stalled word keeps its count
  `MET_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(escape_count_o), "escape count dropped or changed while stalled")

  // busy straight after taking a word
  `MET_ASSERT_NXT(a_busy_after_take, in_take, !in_ready_o, "ready straight after accept")

  // mapping through MWR, MXR, MHI and MYI keeps the engine busy
  `MET_ASSERT_IMP(a_busy_map, in_take, ##5 !in_ready_o, "engine free before mapping done")

  // a result only appears when the engine was busy just before
  `MET_ASSERT_IMP(a_out_from_work, $rose(out_valid_o), $past(!in_ready_o), "result without work")

endmodule

bind mandelbrot_escape_time_pixel met_chk u_met_chk (.*);
